@@ design/multiway_pivot_distributor_macros.svh @@
// ============================================================================
// Assertion macros for the multiway pivot distributor
// Short forms of the concurrent checks used at the end of the top level.
// Both sample on i_clk and are off while i_rst_n is low.
// ============================================================================
`ifndef MULTIWAY_PIVOT_DISTRIBUTOR_MACROS_SVH
`define MULTIWAY_PIVOT_DISTRIBUTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MPD_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MPD_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mpd_pkg.sv @@
// ============================================================================
// mpd_pkg
// Shared widths, codes and the front-to-back command record.
// ============================================================================
package mpd_pkg;

    // Field widths
    localparam int VALUE_W  = 64;
    localparam int BUCKET_W = 4;
    localparam int TOTAL_W  = 32;
    localparam int CFG_W    = 5;

    // Defaults and fixed sizes
    localparam int DEF_MAX_BUCKETS = 16;
    localparam int DEF_BLOCK_ELEMS = 512;
    localparam int HW_BUCKET_LIMIT = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    // Result kinds
    localparam logic KIND_ROUTED = 1'b0;
    localparam logic KIND_TOTAL  = 1'b1;

    // One routed element, classified by the front
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [BUCKET_W-1:0]       bucket;
        logic                      run_end;  // last routed element of its request
        logic                      eos;      // bucket totals follow this element
    } t_cmd;

endpackage

@@ design/mpd_if.sv @@
// ============================================================================
// mpd_in_if / mpd_out_if
// Valid/ready channels for stream elements and for results.
// ============================================================================
interface mpd_in_if
    import mpd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      end_of_stream;

    modport source (output valid, value, end_of_stream, input ready);
    modport sink   (input valid, value, end_of_stream, output ready);
endinterface

interface mpd_out_if
    import mpd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [BUCKET_W-1:0]       bucket;
    logic signed [VALUE_W-1:0] element;
    logic                      closes_block;
    logic [TOTAL_W-1:0]        bucket_total;
    logic                      last_of_run;

    modport source (output valid, kind, bucket, element, closes_block,
                    bucket_total, last_of_run, input ready);
    modport sink   (input valid, kind, bucket, element, closes_block,
                    bucket_total, last_of_run, output ready);
endinterface

@@ design/mpd_queue.sv @@
// ============================================================================
// mpd_queue
// Short FIFO of classified commands between the front and the back.
// ============================================================================
module mpd_queue
    import mpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

@@ design/mpd_front.sv @@
// ============================================================================
// mpd_front
// Accepts stream elements, builds the sorted pivot set, replays the held
// elements once the pivots are settled, and classifies every element.
// ============================================================================
module mpd_front
    import mpd_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BUCKET_W:0] i_buckets,
    mpd_in_if.sink            i_in,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output t_cmd              o_cmd
);

    localparam int LIM      = (MAX_BUCKETS < HW_BUCKET_LIMIT) ? MAX_BUCKETS
                                                               : HW_BUCKET_LIMIT;
    localparam int NPIV_MAX = LIM - 1;
    localparam int CAP_W    = $clog2(LIM);
    localparam int IDX_W    = (NPIV_MAX > 1) ? $clog2(NPIV_MAX) : 1;

    typedef enum logic {S_TAKE, S_REPLAY} t_state;

    t_state                    r_state;
    logic [CAP_W-1:0]          r_cap;
    logic [CAP_W-1:0]          r_idx;
    logic                      r_eos;
    logic signed [VALUE_W-1:0] r_pivot [NPIV_MAX];
    logic signed [VALUE_W-1:0] r_held  [NPIV_MAX];
    logic signed [VALUE_W-1:0] n_pivot [NPIV_MAX];
    logic signed [VALUE_W-1:0] shifted [NPIV_MAX];

    logic [BUCKET_W:0]         buckets_m1;
    logic [CAP_W-1:0]          npiv;
    logic                      capturing;
    logic                      cap_done;
    logic                      accept;
    logic                      push;
    logic                      rep_last;
    logic signed [VALUE_W-1:0] cls_x;
    logic                      cls_hit;
    logic [BUCKET_W-1:0]       cls_j;
    logic [CAP_W-1:0]          ins_pos;

    assign buckets_m1 = i_buckets - 1'b1;
    assign npiv       = buckets_m1[CAP_W-1:0];
    assign capturing  = (r_cap < npiv);
    assign cap_done   = ((r_cap + 1'b1) == npiv);
    assign i_in.ready = (r_state == S_TAKE) && i_cmd_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign rep_last   = (r_idx == (r_cap - 1'b1));

    // Element under classification: replayed held value or live input
    assign cls_x = (r_state == S_REPLAY) ? r_held[r_idx[IDX_W-1:0]] : i_in.value;

    // First captured pivot at or above the element; last bucket otherwise
    always_comb begin
        cls_hit = 1'b0;
        cls_j   = '0;
        for (int i = NPIV_MAX - 1; i >= 0; i--) begin
            if ((CAP_W'(i) < r_cap) && ($signed(cls_x) <= $signed(r_pivot[i]))) begin
                cls_hit = 1'b1;
                cls_j   = BUCKET_W'(i);
            end
        end
        if (!cls_hit) begin
            cls_j = buckets_m1[BUCKET_W-1:0];
        end
    end

    // Insertion slot: after every pivot not above the new value
    always_comb begin
        ins_pos = r_cap;
        for (int i = NPIV_MAX - 1; i >= 0; i--) begin
            if ((CAP_W'(i) < r_cap) && ($signed(r_pivot[i]) > $signed(i_in.value))) begin
                ins_pos = CAP_W'(i);
            end
        end
    end

    // Pivot set with the new value slotted in
    always_comb begin
        shifted[0] = r_pivot[0];
        for (int k = 1; k < NPIV_MAX; k++) begin
            shifted[k] = r_pivot[k-1];
        end
        for (int k = 0; k < NPIV_MAX; k++) begin
            if (CAP_W'(k) < ins_pos) begin
                n_pivot[k] = r_pivot[k];
            end else if (CAP_W'(k) == ins_pos) begin
                n_pivot[k] = i_in.value;
            end else begin
                n_pivot[k] = shifted[k];
            end
        end
    end

    // Command toward the back
    assign o_cmd_valid    = (r_state == S_REPLAY) || (accept && !capturing);
    assign push           = o_cmd_valid && i_cmd_ready;
    assign o_cmd.value    = cls_x;
    assign o_cmd.bucket   = cls_j;
    assign o_cmd.run_end  = (r_state == S_REPLAY) ? rep_last : 1'b1;
    assign o_cmd.eos      = (r_state == S_REPLAY) ? (r_eos && rep_last)
                                                  : i_in.end_of_stream;

    // Capture / replay sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_cap   <= '0;
            r_idx   <= '0;
            r_eos   <= 1'b0;
        end else if (i_cfg_we) begin
            r_state <= S_TAKE;
            r_cap   <= '0;
        end else begin
            unique case (r_state)
                S_TAKE: begin
                    if (accept) begin
                        if (capturing) begin
                            r_cap <= r_cap + 1'b1;
                            if (cap_done || i_in.end_of_stream) begin
                                r_state <= S_REPLAY;
                                r_idx   <= '0;
                                r_eos   <= i_in.end_of_stream;
                            end
                        end else if (i_in.end_of_stream) begin
                            r_cap <= '0;
                        end
                    end
                end
                S_REPLAY: begin
                    if (push) begin
                        if (rep_last) begin
                            r_state <= S_TAKE;
                            if (r_eos) begin
                                r_cap <= '0;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end

    // Pivot and held-value storage
    always_ff @(posedge i_clk) begin
        if (accept && capturing) begin
            for (int k = 0; k < NPIV_MAX; k++) begin
                r_pivot[k] <= n_pivot[k];
            end
            r_held[r_cap[IDX_W-1:0]] <= i_in.value;
        end
    end

endmodule

@@ design/mpd_back.sv @@
// ============================================================================
// mpd_back
// Applies routed elements to the per-bucket block and total counters,
// emits the bucket totals at end of stream, and holds the result register.
// ============================================================================
module mpd_back
    import mpd_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int BLOCK_ELEMS = DEF_BLOCK_ELEMS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BUCKET_W:0] i_buckets,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  t_cmd              i_cmd,
    mpd_out_if.source         o_out
);

    localparam int LIM    = (MAX_BUCKETS < HW_BUCKET_LIMIT) ? MAX_BUCKETS
                                                             : HW_BUCKET_LIMIT;
    localparam int BIDX_W = $clog2(LIM);
    localparam int FILL_W = (BLOCK_ELEMS > 1) ? $clog2(BLOCK_ELEMS) : 1;
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_ELEMS - 1);

    typedef enum logic {S_ROUTE, S_TOTALS} t_state;

    t_state                    r_state;
    logic [BIDX_W-1:0]         r_tidx;
    logic [FILL_W-1:0]         r_fill  [LIM];
    logic [TOTAL_W-1:0]        r_total [LIM];
    logic                      r_out_valid;
    logic                      r_kind;
    logic [BUCKET_W-1:0]       r_bucket;
    logic signed [VALUE_W-1:0] r_element;
    logic                      r_closes;
    logic [TOTAL_W-1:0]        r_total_out;
    logic                      r_last;

    logic [BUCKET_W:0]         buckets_m1;
    logic                      out_free;
    logic                      pop;
    logic [BIDX_W-1:0]         j;
    logic                      fill_hit;
    logic                      t_last;

    assign buckets_m1  = i_buckets - 1'b1;
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_cmd_ready = (r_state == S_ROUTE) && out_free;
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign j           = i_cmd.bucket[BIDX_W-1:0];
    assign fill_hit    = (r_fill[j] == FILL_LAST);
    assign t_last      = (r_tidx == buckets_m1[BIDX_W-1:0]);

    // Result port
    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.bucket       = r_bucket;
    assign o_out.element      = r_element;
    assign o_out.closes_block = r_closes;
    assign o_out.bucket_total = r_total_out;
    assign o_out.last_of_run  = r_last;

    // Counters, totals sweep and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ROUTE;
            r_tidx      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LIM; i++) begin
                r_fill[i]  <= '0;
                r_total[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_state     <= S_ROUTE;
            r_tidx      <= '0;
            r_out_valid <= r_out_valid && !o_out.ready;
            for (int i = 0; i < LIM; i++) begin
                r_fill[i]  <= '0;
                r_total[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_ROUTE: begin
                    if (pop) begin
                        r_fill[j] <= fill_hit ? '0 : r_fill[j] + 1'b1;
                        if (!(&r_total[j])) begin
                            r_total[j] <= r_total[j] + 1'b1;
                        end
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_ROUTED;
                        r_bucket    <= i_cmd.bucket;
                        r_element   <= i_cmd.value;
                        r_closes    <= fill_hit;
                        r_total_out <= '0;
                        r_last      <= i_cmd.run_end && !i_cmd.eos;
                        if (i_cmd.eos) begin
                            r_state <= S_TOTALS;
                            r_tidx  <= '0;
                        end
                    end else if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_TOTALS: begin
                    // out_free low means the held result stays valid
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_TOTAL;
                        r_bucket    <= BUCKET_W'(r_tidx);
                        r_element   <= '0;
                        r_closes    <= 1'b0;
                        r_total_out <= r_total[r_tidx];
                        r_last      <= t_last;
                        if (t_last) begin
                            r_state <= S_ROUTE;
                            for (int i = 0; i < LIM; i++) begin
                                r_fill[i]  <= '0;
                                r_total[i] <= '0;
                            end
                        end else begin
                            r_tidx <= r_tidx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_ROUTE;
            endcase
        end
    end

endmodule

@@ design/multiway_pivot_distributor.sv @@
// ============================================================================
// multiway_pivot_distributor
// One partition pass of a sample sort: pivots from the stream head, then
// every element routed to its bucket, with block marks and bucket totals.
// ============================================================================
// Use: elements arrive on i_in (value, end_of_stream) with valid/ready;
// results leave on o_out with valid/ready. i_cfg_we/i_cfg_data write the
// bucket count (2..16, clamped) and clear the stream state; write it only
// while the block is idle.
// The first bucket_count-1 elements are captured as pivots at one per cycle
// while the command queue has room, and produce no result. The element
// that completes the pivot set (or an earlier end_of_stream) holds the input
// while the held elements are replayed. After that, one element per cycle
// is routed while the receiver keeps up, set by the parallel pivot compare
// in the front and the counter update in the back. A routed result passes
// the command queue and the result register before it can be taken; a
// replayed one passes the front replay state first. End of stream adds
// bucket_count total results from the back, one per cycle unless stalled;
// the front keeps accepting until the four-entry command queue fills.
// Reset (synchronous, active low) restores a bucket count of 4 and empties
// the stream state. When the receiver stalls, the result register holds,
// the queue fills and then i_in.ready drops.
// ============================================================================
`include "multiway_pivot_distributor_macros.svh"

module multiway_pivot_distributor
    import mpd_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int BLOCK_ELEMS = DEF_BLOCK_ELEMS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    mpd_in_if.sink           i_in,
    mpd_out_if.source        o_out
);

    localparam int LIM = (MAX_BUCKETS < HW_BUCKET_LIMIT) ? MAX_BUCKETS
                                                          : HW_BUCKET_LIMIT;

    logic [CFG_W-1:0]    r_bucket_count;
    logic [BUCKET_W:0]   buckets;
    logic [BUCKET_W:0]   buckets_m1;
    logic [BUCKET_W-1:0] top_bucket;
    logic                out_total;

    logic              fq_valid;
    logic              fq_ready;
    t_cmd              fq_cmd;
    logic              qb_valid;
    logic              qb_ready;
    t_cmd              qb_cmd;

    // Bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    // Effective bucket count
    always_comb begin
        priority if (r_bucket_count < 5'd2) begin
            buckets = 5'd2;
        end else if (r_bucket_count > (BUCKET_W+1)'(LIM)) begin
            buckets = (BUCKET_W+1)'(LIM);
        end else begin
            buckets = r_bucket_count;
        end
    end

    assign buckets_m1 = buckets - 1'b1;

    mpd_front #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_buckets   (buckets),
        .i_in        (i_in),
        .o_cmd_valid (fq_valid),
        .i_cmd_ready (fq_ready),
        .o_cmd       (fq_cmd)
    );

    mpd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_data  (fq_cmd),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_data   (qb_cmd)
    );

    mpd_back #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .BLOCK_ELEMS (BLOCK_ELEMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_buckets   (buckets),
        .i_cmd_valid (qb_valid),
        .o_cmd_ready (qb_ready),
        .i_cmd       (qb_cmd),
        .o_out       (o_out)
    );

    // Checks
    assign top_bucket = buckets_m1[BUCKET_W-1:0];
    assign out_total  = o_out.valid && (o_out.kind == KIND_TOTAL);

    `MPD_CHECK_NOW(a_bucket_in_range, o_out.valid,
        o_out.bucket <= top_bucket, "result bucket beyond bucket count")
    `MPD_CHECK_NOW(a_totals_end_on_top, out_total && o_out.last_of_run,
        o_out.bucket == top_bucket, "totals ended before the top bucket")
    `MPD_CHECK_NOW(a_total_clean, out_total,
        o_out.element == '0 && !o_out.closes_block, "total result carries element data")
    `MPD_CHECK_NEXT(a_totals_step,
        out_total && o_out.ready && !i_cfg_we && !o_out.last_of_run,
        out_total && o_out.bucket == $past(o_out.bucket) + 4'd1,
        "totals sweep skipped a bucket")

endmodule

@@ dv/tb_multiway_pivot_distributor.sv @@
// ============================================================================
// tb_multiway_pivot_distributor
// Self-checking bench: a scoreboard class predicts every routed element and
// every end-of-stream bucket total, and compares them with the block output.
// Directed streams first, then a backpressure stream with a long receiver
// hold-off, then random streams at random bucket counts with random idling.
// ============================================================================
module tb_multiway_pivot_distributor;
    import mpd_pkg::*;

    localparam int BUCKET_LIMIT  = (DEF_MAX_BUCKETS < HW_BUCKET_LIMIT) ?
                                   DEF_MAX_BUCKETS : HW_BUCKET_LIMIT;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 360;
    localparam int PRESS_ITEMS   = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // One result as it leaves the block
    typedef struct {
        logic                      kind;
        logic [BUCKET_W-1:0]       bucket;
        logic signed [VALUE_W-1:0] element;
        logic                      closes;
        logic [TOTAL_W-1:0]        total;
        logic                      last;
    } t_dist_result;

    // ------------------------------------------------------------------------
    // Partition predictor and result checker
    // ------------------------------------------------------------------------
    class dist_scoreboard;
        logic [CFG_W-1:0]          bucket_cfg;
        logic signed [VALUE_W-1:0] pivots [HW_BUCKET_LIMIT];
        logic signed [VALUE_W-1:0] held [HW_BUCKET_LIMIT];
        int unsigned               captured;
        int unsigned               fill [HW_BUCKET_LIMIT];
        logic [TOTAL_W-1:0]        totals [HW_BUCKET_LIMIT];
        t_dist_result              expected_q [$];
        t_dist_result              run_q [$];
        int unsigned               mismatches;
        int unsigned               checked;
        int unsigned               closes_seen;

        function new();
            bucket_cfg  = CFG_RESET;
            mismatches  = 0;
            checked     = 0;
            closes_seen = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            captured = 0;
            for (int unsigned i = 0; i < HW_BUCKET_LIMIT; i++) begin
                fill[i]   = 0;
                totals[i] = '0;
            end
        endfunction

        // Register write: takes effect and drops the stream in progress
        function void set_bucket_count(logic [CFG_W-1:0] cfg);
            bucket_cfg = cfg;
            clear_stream();
        endfunction

        // Bucket count after clamping to 2..limit
        function int unsigned active_buckets();
            int unsigned b;
            b = int'(bucket_cfg);
            if (b < 2) b = 2;
            if (b > BUCKET_LIMIT) b = BUCKET_LIMIT;
            return b;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // First bucket whose pivot is >= the value, else the last bucket
        function void route_value(logic signed [VALUE_W-1:0] v, int unsigned nb,
                                  int unsigned np);
            int unsigned  j;
            bit           found;
            t_dist_result r;
            j     = nb - 1;
            found = 1'b0;
            for (int unsigned i = 0; i < np; i++) begin
                if (!found && v <= pivots[i]) begin
                    j     = i;
                    found = 1'b1;
                end
            end
            if (totals[j] != '1) totals[j]++;
            fill[j]++;
            r.kind    = KIND_ROUTED;
            r.bucket  = j[BUCKET_W-1:0];
            r.element = v;
            r.closes  = 1'b0;
            r.total   = '0;
            r.last    = 1'b0;
            if (fill[j] >= DEF_BLOCK_ELEMS) begin
                fill[j]  = 0;
                r.closes = 1'b1;
            end
            run_q.push_back(r);
        endfunction

        // Accepted request: work out every result it causes
        function void note_request(logic signed [VALUE_W-1:0] v, logic eos);
            int unsigned  nb;
            int unsigned  np;
            int unsigned  pos;
            t_dist_result r;
            nb = active_buckets();
            np = nb - 1;
            run_q.delete();
            if (captured < np) begin
                // insertion into the sorted pivot set, value also held
                pos = captured;
                while (pos > 0 && pivots[pos-1] > v) begin
                    pivots[pos] = pivots[pos-1];
                    pos--;
                end
                pivots[pos]    = v;
                held[captured] = v;
                captured++;
                // replay held values once pivots complete or stream ends short
                if (captured == np || eos) begin
                    for (int unsigned i = 0; i < captured; i++)
                        route_value(held[i], nb, captured);
                end
            end else begin
                route_value(v, nb, np);
            end
            if (eos) begin
                for (int unsigned i = 0; i < nb; i++) begin
                    r.kind    = KIND_TOTAL;
                    r.bucket  = i[BUCKET_W-1:0];
                    r.element = '0;
                    r.closes  = 1'b0;
                    r.total   = totals[i];
                    r.last    = 1'b0;
                    run_q.push_back(r);
                end
                clear_stream();
            end
            if (run_q.size() > 0) begin
                r      = run_q.pop_back();
                r.last = 1'b1;
                run_q.push_back(r);
            end
            foreach (run_q[i]) expected_q.push_back(run_q[i]);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(t_dist_result got);
            t_dist_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result with none expected: kind=%0d bucket=%0d elem=%h",
                             got.kind, got.bucket, got.element,
                             " closes=%0d total=%0d last=%0d",
                             got.closes, got.total, got.last);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.kind !== want.kind || got.bucket !== want.bucket ||
                got.element !== want.element || got.closes !== want.closes ||
                got.total !== want.total || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result %0d exp kind=%0d bucket=%0d elem=%h closes=%0d",
                             checked, want.kind, want.bucket, want.element, want.closes,
                             " total=%0d last=%0d", want.total, want.last);
                    $display("       got kind=%0d bucket=%0d elem=%h closes=%0d",
                             got.kind, got.bucket, got.element, got.closes,
                             " total=%0d last=%0d", got.total, got.last);
                end
            end else if (got.closes) begin
                closes_seen++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and channels
    // ------------------------------------------------------------------------
    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    mpd_in_if  in_if ();
    mpd_out_if out_if ();

    multiway_pivot_distributor DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    dist_scoreboard            sb;
    bit                        hold_req;
    bit                        tx_steady;
    int unsigned               burst_left;
    int unsigned               items_sent;
    int unsigned               streams_done;
    int unsigned               cfg_writes;
    logic signed [VALUE_W-1:0] recent [8];
    int unsigned               recent_wr;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mix of extremes, values near zero, repeats and neighbors of recent values
    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: begin
                v = VALUE_W'($urandom_range(0, 40));
                v = v - 64'sd20;
            end
            3, 4: v = recent[$urandom_range(0, 7)];
            5: begin
                v = recent[$urandom_range(0, 7)];
                v = v + VALUE_W'($urandom_range(0, 2)) - 64'sd1;
            end
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    // Bucket count with the clamped extremes well represented
    function automatic logic [CFG_W-1:0] pick_cfg();
        logic [CFG_W-1:0] c;
        case ($urandom_range(0, 5))
            0: c = CFG_W'($urandom_range(0, 1));
            1: c = 5'd2;
            2: c = 5'd16;
            3: c = CFG_W'($urandom_range(17, 31));
            default: c = CFG_W'($urandom_range(2, 16));
        endcase
        return c;
    endfunction

    // Offer one request and wait for it to be taken; bursts with random gaps
    task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic eos);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = tx_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid         <= 1'b1;
        in_if.value         <= v;
        in_if.end_of_stream <= eos;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(v, eos);
        items_sent++;
        if (eos) streams_done++;
        recent[recent_wr] = v;
        recent_wr = (recent_wr + 1) % 8;
    endtask

    task automatic send_stream(input int unsigned len, input bit with_eos);
        for (int unsigned k = 0; k < len; k++)
            send_value(rand_value(), with_eos && (k == len - 1));
    endtask

    // Stop offering, drain all expected results, then let the pipe empty
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bucket_count(input logic [CFG_W-1:0] cfg);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cfg;
        @(posedge i_clk);
        sb.set_bucket_count(cfg);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: checks results, stalls on its own pattern, long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned  mode;
        int unsigned  mode_left;
        int unsigned  pat;
        int unsigned  hold_left;
        bit           hold_taken;
        t_dist_result got;
        mode       = 0;
        mode_left  = 0;
        pat        = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.kind    = out_if.kind;
                got.bucket  = out_if.bucket;
                got.element = out_if.element;
                got.closes  = out_if.closes_block;
                got.total   = out_if.bucket_total;
                got.last    = out_if.last_of_run;
                sb.check_result(got);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            pat++;
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (!hold_req) hold_taken = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    2: out_if.ready <= ((pat % 5) >= 2);
                    default: out_if.ready <= ($urandom_range(0, 9) < 4);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned nb;
        int unsigned np;
        int unsigned len;
        int unsigned rand_start;
        sb           = new();
        burst_left   = 0;
        tx_steady    = 1'b0;
        items_sent   = 0;
        streams_done = 0;
        cfg_writes   = 0;
        recent_wr    = 0;
        for (int i = 0; i < 8; i++) recent[i] = {$urandom(), $urandom()};
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.value         = '0;
        in_if.end_of_stream = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset bucket count: a pivot at the minimum, equal hits, maximum to last bucket
        send_value(VAL_MIN, 1'b0);
        send_value(64'sd100, 1'b0);
        send_value(64'sd0, 1'b0);
        send_value(VAL_MAX, 1'b0);
        send_value(-64'sd1, 1'b0);
        send_value(64'sd100, 1'b1);

        // Count below range acts as two buckets
        write_bucket_count(5'd0);
        send_value(64'sd7, 1'b0);
        send_value(64'sd8, 1'b0);
        send_value(64'sd7, 1'b1);

        // Count above range, short stream routed on captured pivots only
        write_bucket_count(5'd31);
        send_value(-64'sd3, 1'b0);
        send_value(VAL_MAX, 1'b0);
        send_value(-64'sd3, 1'b0);
        send_value(64'sd9, 1'b1);

        // Single-element stream
        write_bucket_count(5'd1);
        send_value(VAL_MIN, 1'b1);

        // Register writes in the middle of pivot capture drop the stream
        write_bucket_count(5'd17);
        send_value(64'sd11, 1'b0);
        send_value(64'sd22, 1'b0);
        send_value(64'sd33, 1'b0);
        write_bucket_count(5'd16);
        send_value(64'sd44, 1'b0);
        send_value(64'sd55, 1'b0);
        write_bucket_count(5'd3);

        // Equal pivots; end of stream on the element that completes the pivots
        send_value(64'sd0, 1'b0);
        send_value(64'sd0, 1'b0);
        send_value(64'sd0, 1'b1);
        send_value(64'sd5, 1'b0);
        send_value(64'sd4, 1'b1);

        // Backpressure: top pivot, everything lands in bucket zero; the
        // receiver holds off long enough for the input to back up
        write_bucket_count(5'd2);
        tx_steady = 1'b1;
        hold_req <= 1'b1;
        send_value(VAL_MAX, 1'b0);
        send_stream(PRESS_ITEMS, 1'b1);
        hold_req <= 1'b0;
        tx_steady = 1'b0;

        // Random streams: mostly complete, some short, some abandoned
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) write_bucket_count(pick_cfg());
            nb = sb.active_buckets();
            np = nb - 1;
            case ($urandom_range(0, 9))
                0: begin
                    len = $urandom_range(1, np);
                    send_stream(len, 1'b1);
                end
                1: begin
                    len = $urandom_range(1, np);
                    send_stream(len, 1'b0);
                    write_bucket_count(pick_cfg());
                end
                default: begin
                    len = np + $urandom_range(0, 40);
                    send_stream(len, 1'b1);
                end
            endcase
        end

        settle();
        $display("Summary: %0d requests in %0d complete streams, %0d bucket count writes",
                 items_sent, streams_done, cfg_writes);
        $display("Summary: %0d results checked, %0d block closes seen, %0d mismatches",
                 sb.checked, sb.closes_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/mpd_pkg.sv
design/mpd_if.sv
design/mpd_queue.sv
design/mpd_front.sv
design/mpd_back.sv
design/multiway_pivot_distributor.sv
dv/tb_multiway_pivot_distributor.sv
